// ----- rtl/tdc_pkg.sv -----
// Shared types, constants and digit helpers for the tick-driven time-of-day clock.
// Used by tdc_time_digits and tick_driven_time_of_day_clock_core; no dependencies.
`default_nettype none

package tdc_pkg;

  // Fractional divider: four seconds of 18 ticks, then one of 19
  localparam logic [4:0] TICKS_SHORT   = 5'd18;
  localparam logic [4:0] TICKS_LONG    = 5'd19;
  localparam logic [2:0] GROUP_SECONDS = 3'd5;

  // Default spinner length
  localparam int SPINNER_GLYPHS_DEF = 4;

  // Input word commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CLOCK_ACTIVE   = 3'd0,
    REG_CLOCK_SHOWN    = 3'd1,
    REG_SHOW_SECONDS   = 3'd2,
    REG_SPINNER_SHOWN  = 3'd3,
    REG_SPINNER_GLYPHS = 3'd4
  } cfg_reg_t;

  // Decimal clock digits
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
  } digits_t;

  // Per-word control toward the digit counter
  typedef struct packed {
    logic advance;
    logic load;
  } digit_ctrl_t;

  // Tens digit of a value in 0..59
  function automatic logic [2:0] tens_digit(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd50)      t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  // Units digit of a value in 0..59
  function automatic logic [3:0] units_digit(input logic [5:0] v);
    logic [2:0] t;
    logic [5:0] r;
    t = tens_digit(v);
    r = v - {t, 3'b000} - {2'b00, t, 1'b0};
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tdc_time_digits.sv -----
// Decimal hh:mm:ss counter with 24-hour wrap and checked time load.
// Depends on tdc_pkg for the digit struct, control struct and digit helpers.
`default_nettype none

module tdc_time_digits (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tdc_pkg::digit_ctrl_t ctrl,
  input  wire logic [4:0]         load_hours,
  input  wire logic [5:0]         load_minutes,
  input  wire logic [5:0]         load_seconds,
  output tdc_pkg::digits_t        digits_nxt
);

  tdc_pkg::digits_t digits_r;

  logic [4:0] su_inc;
  logic [3:0] st_inc;
  logic [4:0] mu_inc;
  logic [3:0] mt_inc;
  logic [4:0] hu_inc;
  logic       load_ok;

  assign su_inc  = {1'b0, digits_r.second_units} + 5'd1;
  assign st_inc  = {1'b0, digits_r.second_tens} + 4'd1;
  assign mu_inc  = {1'b0, digits_r.minute_units} + 5'd1;
  assign mt_inc  = {1'b0, digits_r.minute_tens} + 4'd1;
  assign hu_inc  = {1'b0, digits_r.hour_units} + 5'd1;
  assign load_ok = (load_hours <= 5'd23) && (load_minutes <= 6'd59) &&
                   (load_seconds <= 6'd59);

  // Load or ripple one second through the digits
  always_comb begin
    digits_nxt = digits_r;
    if (ctrl.load) begin
      if (load_ok) begin
        digits_nxt.hour_tens    = 2'(tdc_pkg::tens_digit({1'b0, load_hours}));
        digits_nxt.hour_units   = tdc_pkg::units_digit({1'b0, load_hours});
        digits_nxt.minute_tens  = tdc_pkg::tens_digit(load_minutes);
        digits_nxt.minute_units = tdc_pkg::units_digit(load_minutes);
        digits_nxt.second_tens  = tdc_pkg::tens_digit(load_seconds);
        digits_nxt.second_units = tdc_pkg::units_digit(load_seconds);
      end
    end else if (ctrl.advance) begin
      if (su_inc <= 5'd9) begin
        digits_nxt.second_units = su_inc[3:0];
      end else begin
        digits_nxt.second_units = 4'd0;
        if (st_inc <= 4'd5) begin
          digits_nxt.second_tens = st_inc[2:0];
        end else begin
          digits_nxt.second_tens = 3'd0;
          if (mu_inc <= 5'd9) begin
            digits_nxt.minute_units = mu_inc[3:0];
          end else begin
            digits_nxt.minute_units = 4'd0;
            if (mt_inc <= 4'd5) begin
              digits_nxt.minute_tens = mt_inc[2:0];
            end else begin
              digits_nxt.minute_tens = 3'd0;
              if (hu_inc > 5'd9) begin
                digits_nxt.hour_units = 4'd0;
                digits_nxt.hour_tens  = digits_r.hour_tens + 2'd1;
              end else if (hu_inc == 5'd4 && digits_r.hour_tens == 2'd2) begin
                digits_nxt.hour_units = 4'd0;
                digits_nxt.hour_tens  = 2'd0;
              end else begin
                digits_nxt.hour_units = hu_inc[3:0];
              end
            end
          end
        end
      end
    end
  end

  // Hold the clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
    end else begin
      digits_r <= digits_nxt;
    end
  end

  // A load never moves the clock by a tick, and an illegal one leaves it alone
  a_illegal_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load && !load_ok |-> digits_nxt == digits_r)
    else $error("illegal load changed the clock");

  a_minutes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    digits_r.minute_tens <= 3'd5 && digits_r.second_tens <= 3'd5)
    else $error("tens digit out of range");

  a_hours_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    digits_r.hour_tens != 2'd3 &&
    !(digits_r.hour_tens == 2'd2 && digits_r.hour_units > 4'd3))
    else $error("hours beyond 23");

endmodule

`default_nettype wire

// ----- rtl/tick_driven_time_of_day_clock_core.sv -----
// Top level of the tick-driven time-of-day clock: divider, spinner, tick count
// and result register. Depends on tdc_pkg and tdc_time_digits.
//
// Usage: each input word is either a timer tick (in_cmd = 0) or a time load
// (in_cmd = 1), moved when in_valid is high and in_stall is low. Every word
// yields exactly one result word on the out_ channel, moved when out_valid is
// high and out_stall is low. The result of a word is registered and appears in the
// cycle after it is taken; one word is taken per cycle while in_stall is low, so
// throughput is one word per clock, set by the single result register.
// When the receiver stalls with a result pending, in_stall rises in the same
// cycle and the pending result holds until taken; while out_stall is low a
// new word is taken in the same cycle as the old result leaves.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data,
// always ready; writes to indexes beyond the register list are dropped.
// Synchronous reset (rst_n low) clears the configuration registers, sets the divider
// to the start of a five-second group, zeroes the clock at 00:00:00, the spinner
// position and the tick count, and empties the result register; its payload is not reset.
`default_nettype none

module tick_driven_time_of_day_clock_core #(
  parameter int SPINNER_GLYPHS = tdc_pkg::SPINNER_GLYPHS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_cmd,
  input  wire logic                           in_busy_req,
  input  wire logic [4:0]                     in_load_hours,
  input  wire logic [5:0]                     in_load_minutes,
  input  wire logic [5:0]                     in_load_seconds,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_second_passed,
  output logic                                out_redraw,
  output logic                                out_redraw_seconds,
  output logic [5:0]                          out_hour_tens_char,
  output logic [5:0]                          out_hour_units_char,
  output logic [5:0]                          out_minute_tens_char,
  output logic [5:0]                          out_minute_units_char,
  output logic [5:0]                          out_second_tens_char,
  output logic [5:0]                          out_second_units_char,
  output logic                                out_spinner_update,
  output logic [7:0]                          out_spinner_char,
  output logic [31:0]                         out_tick_total,
  // configuration port
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SPIN_W = (SPINNER_GLYPHS > 2) ? $clog2(SPINNER_GLYPHS) : 1;

  // configuration registers
  logic        clock_active_r;
  logic        clock_shown_r;
  logic        show_seconds_r;
  logic        spinner_shown_r;
  logic [31:0] spinner_glyphs_r;

  // block state
  logic [4:0]        ticks_left_r, ticks_left_nxt;
  logic [2:0]        group_r, group_nxt;
  logic [SPIN_W-1:0] spin_idx_r, spin_idx_nxt;
  logic [31:0]       tick_counter_r, tick_counter_nxt;

  // result register
  logic        out_valid_r;
  logic        sec_r, redraw_r, redraw_sec_r, spin_upd_r;
  logic [7:0]  spin_char_r;
  tdc_pkg::digits_t digits_out_r;

  logic                 in_accept;
  logic                 is_tick;
  logic                 sec_done;
  logic                 spin_step;
  logic [SPIN_W+1:0]    spin_idx_ext;
  logic [1:0]           glyph_sel;
  logic [7:0]           glyph;
  tdc_pkg::digit_ctrl_t digit_ctrl;
  tdc_pkg::digits_t     digits_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign is_tick   = in_accept && (in_cmd == tdc_pkg::CMD_TICK);

  // Decide whether this tick ends a second
  assign sec_done  = is_tick && (ticks_left_r <= 5'd1);

  // Advance the fractional divider
  always_comb begin
    ticks_left_nxt = ticks_left_r;
    group_nxt      = group_r;
    if (is_tick) begin
      if (ticks_left_r > 5'd1) begin
        ticks_left_nxt = ticks_left_r - 5'd1;
      end else if (group_r > 3'd1) begin
        group_nxt      = group_r - 3'd1;
        ticks_left_nxt = tdc_pkg::TICKS_SHORT;
      end else begin
        group_nxt      = tdc_pkg::GROUP_SECONDS;
        ticks_left_nxt = tdc_pkg::TICKS_LONG;
      end
    end
  end

  assign tick_counter_nxt = is_tick ? tick_counter_r + 32'd1 : tick_counter_r;

  // Step the spinner and pick its glyph byte
  assign spin_step    = is_tick && clock_active_r && in_busy_req && spinner_shown_r;
  assign spin_idx_ext = (SPIN_W + 2)'(spin_idx_r);
  assign glyph_sel    = spin_idx_ext[1:0];
  assign glyph        = spinner_glyphs_r[{glyph_sel, 3'b000} +: 8];

  always_comb begin
    spin_idx_nxt = spin_idx_r;
    if (spin_step) begin
      if (spin_idx_r == SPIN_W'(SPINNER_GLYPHS - 1)) begin
        spin_idx_nxt = '0;
      end else begin
        spin_idx_nxt = spin_idx_r + SPIN_W'(1);
      end
    end
  end

  // Clock digits
  assign digit_ctrl.advance = sec_done;
  assign digit_ctrl.load    = in_accept && (in_cmd == tdc_pkg::CMD_LOAD);

  tdc_time_digits u_digits (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (digit_ctrl),
    .load_hours   (in_load_hours),
    .load_minutes (in_load_minutes),
    .load_seconds (in_load_seconds),
    .digits_nxt   (digits_nxt)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_active_r   <= 1'b0;
      clock_shown_r    <= 1'b0;
      show_seconds_r   <= 1'b0;
      spinner_shown_r  <= 1'b0;
      spinner_glyphs_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tdc_pkg::REG_CLOCK_ACTIVE:   clock_active_r   <= cfg_data[0];
        tdc_pkg::REG_CLOCK_SHOWN:    clock_shown_r    <= cfg_data[0];
        tdc_pkg::REG_SHOW_SECONDS:   show_seconds_r   <= cfg_data[0];
        tdc_pkg::REG_SPINNER_SHOWN:  spinner_shown_r  <= cfg_data[0];
        tdc_pkg::REG_SPINNER_GLYPHS: spinner_glyphs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold divider, spinner and tick count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_left_r   <= tdc_pkg::TICKS_SHORT;
      group_r        <= tdc_pkg::GROUP_SECONDS;
      spin_idx_r     <= '0;
      tick_counter_r <= '0;
    end else begin
      ticks_left_r   <= ticks_left_nxt;
      group_r        <= group_nxt;
      spin_idx_r     <= spin_idx_nxt;
      tick_counter_r <= tick_counter_nxt;
    end
  end

  // Track the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sec_r          <= sec_done;
      redraw_r       <= sec_done && clock_active_r && clock_shown_r;
      redraw_sec_r   <= sec_done && clock_active_r && clock_shown_r && show_seconds_r;
      spin_upd_r     <= spin_step;
      spin_char_r    <= spin_step ? glyph : 8'd0;
      digits_out_r   <= digits_nxt;
      out_tick_total <= tick_counter_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_second_passed     = sec_r;
  assign out_redraw            = redraw_r;
  assign out_redraw_seconds    = redraw_sec_r;
  assign out_spinner_update    = spin_upd_r;
  assign out_spinner_char      = spin_char_r;
  assign out_hour_tens_char    = {4'b1100, digits_out_r.hour_tens};
  assign out_hour_units_char   = {2'b11, digits_out_r.hour_units};
  assign out_minute_tens_char  = {3'b110, digits_out_r.minute_tens};
  assign out_minute_units_char = {2'b11, digits_out_r.minute_units};
  assign out_second_tens_char  = {3'b110, digits_out_r.second_tens};
  assign out_second_units_char = {2'b11, digits_out_r.second_units};

  a_redraw_needs_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (redraw_r || redraw_sec_r) |-> sec_r && redraw_r)
    else $error("redraw without a completed second");

  a_divider_range: assert property (@(posedge clk) disable iff (!rst_n)
    ticks_left_r >= 5'd1 && ticks_left_r <= tdc_pkg::TICKS_LONG &&
    group_r >= 3'd1 && group_r <= tdc_pkg::GROUP_SECONDS)
    else $error("divider state out of range");

  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_cmd == tdc_pkg::CMD_TICK |=>
    tick_counter_r == $past(tick_counter_r) + 32'd1)
    else $error("tick not counted");

  a_load_keeps_divider: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_cmd == tdc_pkg::CMD_LOAD |=> ticks_left_r == $past(ticks_left_r) &&
    group_r == $past(group_r) && spin_idx_r == $past(spin_idx_r))
    else $error("load disturbed divider or spinner");

  a_idle_spinner_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !spin_upd_r |-> spin_char_r == 8'd0)
    else $error("spinner glyph without update");

endmodule

`default_nettype wire

// ----- tb/tod_clock_checker.sv -----
// Scoreboard for the tick-driven time-of-day clock: watches the input, result and
// register channels, predicts every result word and compares it field by field.
// Depends on tdc_pkg for register codes, divider constants and the digit record.
module tod_clock_checker #(
  parameter int SPINNER_GLYPHS = tdc_pkg::SPINNER_GLYPHS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic        in_busy_req,
  input  logic [4:0]  in_load_hours,
  input  logic [5:0]  in_load_minutes,
  input  logic [5:0]  in_load_seconds,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_second_passed,
  input  logic        out_redraw,
  input  logic        out_redraw_seconds,
  input  logic [5:0]  out_hour_tens_char,
  input  logic [5:0]  out_hour_units_char,
  input  logic [5:0]  out_minute_tens_char,
  input  logic [5:0]  out_minute_units_char,
  input  logic [5:0]  out_second_tens_char,
  input  logic [5:0]  out_second_units_char,
  input  logic        out_spinner_update,
  input  logic [7:0]  out_spinner_char,
  input  logic [31:0] out_tick_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          error_count,
  output int          pending_words,
  output int          words_checked,
  output int          seconds_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   ASCII_ZERO  = 48;

  typedef struct packed {
    logic        second_passed;
    logic        redraw;
    logic        redraw_seconds;
    logic [5:0]  hour_tens_char;
    logic [5:0]  hour_units_char;
    logic [5:0]  minute_tens_char;
    logic [5:0]  minute_units_char;
    logic [5:0]  second_tens_char;
    logic [5:0]  second_units_char;
    logic        spinner_update;
    logic [7:0]  spinner_char;
    logic [31:0] tick_total;
  } tod_word_t;

  // Register copies
  logic        active_r;
  logic        shown_r;
  logic        secs_r;
  logic        spin_shown_r;
  logic [31:0] glyphs_r;

  // Clock state
  logic [4:0]       ticks_left;
  logic [2:0]       group_left;
  tdc_pkg::digits_t clock_now;
  int               spin_pos;
  logic [31:0]      tick_count;

  tod_word_t   due_words[$];
  tod_word_t   want;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v)
      report_mismatch($sformatf("%s: got %0h, expected %0h (result word %0d)",
                                name, got, want_v, words_checked));
  endtask

  // Advance the clock by one accepted word and form the word it must produce
  function automatic tod_word_t step_clock(input logic cmd, input logic busy,
                                           input logic [4:0] hrs, input logic [5:0] mins,
                                           input logic [5:0] secs);
    tod_word_t w;
    w = '0;
    if (cmd == tdc_pkg::CMD_LOAD) begin
      // drop loads with any field out of range
      if (hrs <= 5'd23 && mins <= 6'd59 && secs <= 6'd59) begin
        clock_now.hour_tens    = 2'(hrs / 10);
        clock_now.hour_units   = 4'(hrs % 10);
        clock_now.minute_tens  = 3'(mins / 10);
        clock_now.minute_units = 4'(mins % 10);
        clock_now.second_tens  = 3'(secs / 10);
        clock_now.second_units = 4'(secs % 10);
      end
    end else begin
      tick_count = tick_count + 32'd1;
      if (ticks_left > 5'd1) begin
        ticks_left = ticks_left - 5'd1;
      end else begin
        // four short seconds, then a long one; a zero count also ends a second
        if (group_left > 3'd1) begin
          group_left = group_left - 3'd1;
          ticks_left = tdc_pkg::TICKS_SHORT;
        end else begin
          group_left = tdc_pkg::GROUP_SECONDS;
          ticks_left = tdc_pkg::TICKS_LONG;
        end
        // ripple the carry up through the digits, wrap at 24:00:00
        if (clock_now.second_units < 4'd9) begin
          clock_now.second_units = clock_now.second_units + 4'd1;
        end else begin
          clock_now.second_units = '0;
          if (clock_now.second_tens < 3'd5) begin
            clock_now.second_tens = clock_now.second_tens + 3'd1;
          end else begin
            clock_now.second_tens = '0;
            if (clock_now.minute_units < 4'd9) begin
              clock_now.minute_units = clock_now.minute_units + 4'd1;
            end else begin
              clock_now.minute_units = '0;
              if (clock_now.minute_tens < 3'd5) begin
                clock_now.minute_tens = clock_now.minute_tens + 3'd1;
              end else begin
                clock_now.minute_tens = '0;
                if (clock_now.hour_tens == 2'd2 && clock_now.hour_units == 4'd3) begin
                  clock_now.hour_tens  = '0;
                  clock_now.hour_units = '0;
                end else if (clock_now.hour_units == 4'd9) begin
                  clock_now.hour_units = '0;
                  clock_now.hour_tens  = clock_now.hour_tens + 2'd1;
                end else begin
                  clock_now.hour_units = clock_now.hour_units + 4'd1;
                end
              end
            end
          end
        end
        w.second_passed  = 1'b1;
        w.redraw         = active_r & shown_r;
        w.redraw_seconds = w.redraw & secs_r;
      end
      // step the spinner on busy ticks
      if (active_r && busy && spin_shown_r) begin
        w.spinner_update = 1'b1;
        w.spinner_char   = glyphs_r[8 * (spin_pos % 4) +: 8];
        spin_pos         = (spin_pos + 1 >= SPINNER_GLYPHS) ? 0 : spin_pos + 1;
      end
    end
    w.hour_tens_char    = 6'(ASCII_ZERO + clock_now.hour_tens);
    w.hour_units_char   = 6'(ASCII_ZERO + clock_now.hour_units);
    w.minute_tens_char  = 6'(ASCII_ZERO + clock_now.minute_tens);
    w.minute_units_char = 6'(ASCII_ZERO + clock_now.minute_units);
    w.second_tens_char  = 6'(ASCII_ZERO + clock_now.second_tens);
    w.second_units_char = 6'(ASCII_ZERO + clock_now.second_units);
    w.tick_total        = tick_count;
    return w;
  endfunction

  // Retire results first, then queue the word taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      active_r      = 1'b0;
      shown_r       = 1'b0;
      secs_r        = 1'b0;
      spin_shown_r  = 1'b0;
      glyphs_r      = '0;
      ticks_left    = tdc_pkg::TICKS_SHORT;
      group_left    = tdc_pkg::GROUP_SECONDS;
      clock_now     = '0;
      spin_pos      = 0;
      tick_count    = '0;
      error_count   = 0;
      words_checked = 0;
      seconds_seen  = 0;
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tdc_pkg::REG_CLOCK_ACTIVE:   active_r     = cfg_data[0];
          tdc_pkg::REG_CLOCK_SHOWN:    shown_r      = cfg_data[0];
          tdc_pkg::REG_SHOW_SECONDS:   secs_r       = cfg_data[0];
          tdc_pkg::REG_SPINNER_SHOWN:  spin_shown_r = cfg_data[0];
          tdc_pkg::REG_SPINNER_GLYPHS: glyphs_r     = cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected, tick_total %0h",
                                    out_tick_total));
        end else begin
          want = due_words.pop_front();
          check_field("second_passed", out_second_passed, want.second_passed);
          check_field("redraw", out_redraw, want.redraw);
          check_field("redraw_seconds", out_redraw_seconds, want.redraw_seconds);
          check_field("hour_tens_char", out_hour_tens_char, want.hour_tens_char);
          check_field("hour_units_char", out_hour_units_char, want.hour_units_char);
          check_field("minute_tens_char", out_minute_tens_char, want.minute_tens_char);
          check_field("minute_units_char", out_minute_units_char, want.minute_units_char);
          check_field("second_tens_char", out_second_tens_char, want.second_tens_char);
          check_field("second_units_char", out_second_units_char, want.second_units_char);
          check_field("spinner_update", out_spinner_update, want.spinner_update);
          check_field("spinner_char", out_spinner_char, want.spinner_char);
          check_field("tick_total", out_tick_total, want.tick_total);
          words_checked++;
          if (want.second_passed) seconds_seen++;
        end
      end
      if (in_valid && !in_stall)
        due_words.push_back(step_clock(in_cmd, in_busy_req, in_load_hours,
                                       in_load_minutes, in_load_seconds));
    end
    pending_words = due_words.size();
  end

endmodule

// ----- tb/tick_driven_time_of_day_clock_core_test.sv -----
// Top of the time-of-day clock testbench: clock, reset, register setup, directed and
// random words with random gaps and stalls, and the final verdict.
// Depends on tdc_pkg, tick_driven_time_of_day_clock_core and tod_clock_checker.
module tick_driven_time_of_day_clock_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   SPIN_LEN        = tdc_pkg::SPINNER_GLYPHS_DEF;
  localparam int   PHASES          = 8;
  localparam int   WORDS_PER_PHASE = 125;
  localparam int   CYCLE_LIMIT     = 300000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic        in_busy_req;
  logic [4:0]  in_load_hours;
  logic [5:0]  in_load_minutes;
  logic [5:0]  in_load_seconds;
  logic        out_valid;
  logic        out_stall;
  logic        out_second_passed;
  logic        out_redraw;
  logic        out_redraw_seconds;
  logic [5:0]  out_hour_tens_char;
  logic [5:0]  out_hour_units_char;
  logic [5:0]  out_minute_tens_char;
  logic [5:0]  out_minute_units_char;
  logic [5:0]  out_second_tens_char;
  logic [5:0]  out_second_units_char;
  logic        out_spinner_update;
  logic [7:0]  out_spinner_char;
  logic [31:0] out_tick_total;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int error_count;
  int pending_words;
  int words_checked;
  int seconds_seen;
  int cycle_count   = 0;
  int sender_calm   = 0;
  int receiver_calm = 0;
  int words_sent    = 0;
  int loads_sent    = 0;
  int loads_dropped = 0;

  tick_driven_time_of_day_clock_core #(.SPINNER_GLYPHS(SPIN_LEN)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_busy_req(in_busy_req),
    .in_load_hours(in_load_hours), .in_load_minutes(in_load_minutes),
    .in_load_seconds(in_load_seconds),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_second_passed(out_second_passed), .out_redraw(out_redraw),
    .out_redraw_seconds(out_redraw_seconds),
    .out_hour_tens_char(out_hour_tens_char), .out_hour_units_char(out_hour_units_char),
    .out_minute_tens_char(out_minute_tens_char),
    .out_minute_units_char(out_minute_units_char),
    .out_second_tens_char(out_second_tens_char),
    .out_second_units_char(out_second_units_char),
    .out_spinner_update(out_spinner_update), .out_spinner_char(out_spinner_char),
    .out_tick_total(out_tick_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tod_clock_checker #(.SPINNER_GLYPHS(SPIN_LEN)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_busy_req(in_busy_req),
    .in_load_hours(in_load_hours), .in_load_minutes(in_load_minutes),
    .in_load_seconds(in_load_seconds),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_second_passed(out_second_passed), .out_redraw(out_redraw),
    .out_redraw_seconds(out_redraw_seconds),
    .out_hour_tens_char(out_hour_tens_char), .out_hour_units_char(out_hour_units_char),
    .out_minute_tens_char(out_minute_tens_char),
    .out_minute_units_char(out_minute_units_char),
    .out_second_tens_char(out_second_tens_char),
    .out_second_units_char(out_second_units_char),
    .out_spinner_update(out_spinner_update), .out_spinner_char(out_spinner_char),
    .out_tick_total(out_tick_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending_words(pending_words),
    .words_checked(words_checked), .seconds_seen(seconds_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d words outstanding",
               cycle_count, pending_words);
      $display("tick_driven_time_of_day_clock_core: mismatch");
      $finish;
    end
  end

  // Draw a random idle gap before each word, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic send_word(input logic cmd, input logic busy, input logic [4:0] hrs,
                           input logic [5:0] mins, input logic [5:0] secs);
    int gap;
    gap = draw_gap(sender_calm);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_busy_req     <= busy;
    in_load_hours   <= hrs;
    in_load_minutes <= mins;
    in_load_seconds <= secs;
    do @(posedge clk); while (!(in_valid && !in_stall));
    words_sent++;
    if (cmd == tdc_pkg::CMD_LOAD) begin
      loads_sent++;
      if (hrs > 5'd23 || mins > 6'd59 || secs > 6'd59) loads_dropped++;
    end
  endtask

  task automatic send_tick(input logic busy);
    send_word(tdc_pkg::CMD_TICK, busy, 5'($urandom()), 6'($urandom()), 6'($urandom()));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write every register; flag registers get random upper bits, then a write past the map
  task automatic apply_setting(input logic act, input logic shown, input logic secs,
                               input logic spin, input logic [31:0] glyphs);
    write_reg(tdc_pkg::REG_CLOCK_ACTIVE, {31'($urandom()), act});
    write_reg(tdc_pkg::REG_CLOCK_SHOWN, {31'($urandom()), shown});
    write_reg(tdc_pkg::REG_SHOW_SECONDS, {31'($urandom()), secs});
    write_reg(tdc_pkg::REG_SPINNER_SHOWN, {31'($urandom()), spin});
    write_reg(tdc_pkg::REG_SPINNER_GLYPHS, glyphs);
    write_reg(3'(int'(tdc_pkg::REG_SPINNER_GLYPHS) + $urandom_range(1, 3)), $urandom());
  endtask

  // Drop valid and hold until every result word has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Result side: stall for a random gap before taking each word
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      gap = draw_gap(receiver_calm);
      repeat (gap) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    int          k;
    int          phase;
    int          pick;
    logic [4:0]  hrs;
    logic [5:0]  mins;
    logic [5:0]  secs;
    logic [3:0]  flags;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = tdc_pkg::CMD_TICK;
    in_busy_req     = 1'b0;
    in_load_hours   = '0;
    in_load_minutes = '0;
    in_load_seconds = '0;
    cfg_valid       = 1'b0;
    cfg_index       = tdc_pkg::REG_CLOCK_ACTIVE;
    cfg_data        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: midnight wrap on the first short second, spinner wrap, rejected loads
    apply_setting(1'b1, 1'b1, 1'b1, 1'b1, 32'h7C2F_2D5C);
    send_word(tdc_pkg::CMD_LOAD, 1'b1, 5'd23, 6'd59, 6'd59);
    for (k = 0; k < 18; k++) send_tick(k[0] | k[3]);
    send_word(tdc_pkg::CMD_LOAD, 1'b0, 5'd24, 6'd0, 6'd0);
    send_word(tdc_pkg::CMD_LOAD, 1'b0, 5'd0, 6'd60, 6'd0);
    send_word(tdc_pkg::CMD_LOAD, 1'b0, 5'd0, 6'd0, 6'd60);
    send_word(tdc_pkg::CMD_LOAD, 1'b1, 5'd31, 6'd63, 6'd63);
    send_word(tdc_pkg::CMD_LOAD, 1'b1, 5'd0, 6'd0, 6'd0);
    settle();

    // Random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      flags = 4'($urandom());
      case (phase)
        0:       apply_setting(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
        1:       apply_setting(1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        2:       apply_setting(1'b1, 1'b1, 1'b0, 1'b1, $urandom());
        3:       apply_setting(1'b1, 1'b0, 1'b1, 1'b1, $urandom());
        4:       apply_setting(1'b0, 1'b1, 1'b1, 1'b1, $urandom());
        5:       apply_setting(1'b1, 1'b1, 1'b1, 1'b0, $urandom());
        6:       apply_setting(flags[0], flags[1], flags[2], flags[3], $urandom());
        default: apply_setting(1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
      endcase
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 199);
        if (pick < 4) begin
          // load just short of a digit rollover so the carries get exercised
          case ($urandom_range(0, 3))
            0:       hrs = 5'd23;
            1:       hrs = 5'd9;
            2:       hrs = 5'd19;
            default: hrs = 5'($urandom_range(0, 23));
          endcase
          mins = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
          secs = 6'($urandom_range(57, 59));
          send_word(tdc_pkg::CMD_LOAD, 1'($urandom()), hrs, mins, secs);
        end else if (pick < 6) begin
          send_word(tdc_pkg::CMD_LOAD, 1'($urandom()), 5'($urandom_range(0, 23)),
                    6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
        end else if (pick < 8) begin
          send_word(tdc_pkg::CMD_LOAD, 1'($urandom()), 5'($urandom()), 6'($urandom()),
                    6'($urandom()));
        end else begin
          send_tick(1'($urandom()));
        end
      end
      settle();
    end

    while (pending_words != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("sent %0d words (%0d loads, %0d out of range) over %0d register settings",
             words_sent, loads_sent, loads_dropped, PHASES + 1);
    $display("checked %0d result words, %0d completed seconds, %0d field errors",
             words_checked, seconds_seen, error_count);
    if (error_count == 0) begin
      $display("tick_driven_time_of_day_clock_core: match");
    end else begin
      $display("tick_driven_time_of_day_clock_core: mismatch");
    end
    $finish;
  end

endmodule
